// ===== rtl/harmonic_waveform_synth_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the harmonic waveform synthesiser.
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef HARMONIC_WAVEFORM_SYNTH_CORE_DEFINES_SVH
`define HARMONIC_WAVEFORM_SYNTH_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define HWS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent sequence starting in the cycle after the antecedent.
`define HWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error(msg);

`endif

// ===== rtl/hws_pkg.sv =====
// ----------------------------------------------------------------------------
// hws_pkg
// Types, constants and the harmonic coefficient table of the synthesiser.
// ----------------------------------------------------------------------------
package hws_pkg;

  localparam int MAX_HARMONICS_DEF   = 10;
  localparam int COS_TABLE_DEPTH_DEF = 1024;

  localparam int HC_W       = 4;
  localparam int PHASE_W    = 16;
  localparam int TICK_W     = 16;
  localparam int DC_W       = 18;
  localparam int CODE_W     = 12;
  localparam int COS_W      = 16;
  localparam int MAG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_HARMONIC_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_TICKS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DC_LEVEL       = 3'd3;

  localparam logic [HC_W-1:0]    HARMONIC_COUNT_RST = 4'd1;
  localparam logic [PHASE_W-1:0] PHASE_STEP_RST     = 16'd3277;
  localparam logic [TICK_W-1:0]  WRAP_TICKS_RST     = 16'd2001;
  localparam logic [DC_W-1:0]    DC_LEVEL_RST       = 18'd50279;

  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 21;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int DC_SHIFT    = 15;
  localparam int SCALE_NUM   = 40950;
  localparam int DIV_CONST   = 33;
  localparam int SCALE_SHIFT = 31;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_K     = (1 << RECIP_SHIFT) / DIV_CONST;
  localparam int SCALED_W    = 33;
  localparam int X_W         = 18;
  localparam int Q_W         = 13;

  localparam longint FULL_SCALE_NUM =
    longint'(DIV_CONST) * longint'(4096) * (longint'(1) << SCALE_SHIFT);
  localparam longint CLIP_LIMIT = (FULL_SCALE_NUM + SCALE_NUM - 1) / SCALE_NUM;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_SCALE,
    ST_DIV,
    ST_FIX
  } hws_state_t;

  function automatic logic [31:0] harm_entry(input int unsigned k);
    logic [31:0] e;
    case (k)
      0:       e = {16'd16804, 16'd51057};
      1:       e = {16'd25139, 16'd29646};
      2:       e = {16'd3539,  16'd4186};
      3:       e = {16'd7655,  16'd51204};
      4:       e = {16'd8362,  16'd22479};
      5:       e = {16'd2294,  16'd59661};
      6:       e = {16'd4601,  16'd44310};
      7:       e = {16'd4961,  16'd14686};
      8:       e = {16'd1907,  16'd51042};
      9:       e = {16'd3133,  16'd37082};
      default: e = 32'd0;
    endcase
    return e;
  endfunction

endpackage

// ===== rtl/hws_cos_rom.sv =====
// ----------------------------------------------------------------------------
// hws_cos_rom
// Full-turn Q1.15 cosine table, built at elaboration, with registered read.
// ----------------------------------------------------------------------------
module hws_cos_rom import hws_pkg::*; #(
  parameter int COS_TABLE_DEPTH = COS_TABLE_DEPTH_DEF,
  localparam int ADDR_W = $clog2(COS_TABLE_DEPTH)
) (
  input  logic                    clk,
  input  logic [ADDR_W-1:0]       rd_addr,
  output logic signed [COS_W-1:0] rd_data_r
);

  localparam longint Q30_ONE = longint'(1) << 30;
  localparam longint POLY_COEF [8] = '{
    64'sd1073741824, -64'sd1324675880, 64'sd272375560, -64'sd22401992,
    64'sd987049, -64'sd27061, 64'sd506, -64'sd7
  };

  function automatic logic [COS_W-1:0] quarter_cos(input longint u);
    longint v;
    longint r;
    v = (u * u) >> 30;
    r = POLY_COEF[7];
    for (int n = 6; n >= 0; n--) begin
      r = (r * v) / Q30_ONE + POLY_COEF[n];
    end
    if (r < 0) begin
      r = 0;
    end
    if (r > Q30_ONE) begin
      r = Q30_ONE;
    end
    r = (r + 16384) >>> 15;
    if (r > 32767) begin
      r = 32767;
    end
    return COS_W'(r);
  endfunction

  function automatic logic [COS_W-1:0] cos_entry(input int i);
    longint quarters;
    longint quad;
    longint rem;
    longint u;
    longint w;
    logic [COS_W-1:0] c;
    quarters = longint'(4) * longint'(i);
    quad     = quarters / COS_TABLE_DEPTH;
    rem      = quarters % COS_TABLE_DEPTH;
    u        = (rem << 30) / COS_TABLE_DEPTH;
    w        = Q30_ONE - u;
    case (quad)
      0:       c = quarter_cos(u);
      1:       c = -quarter_cos(w);
      2:       c = -quarter_cos(u);
      default: c = quarter_cos(w);
    endcase
    return c;
  endfunction

  logic [COS_W-1:0] rom_mem [COS_TABLE_DEPTH];

  for (genvar g = 0; g < COS_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [COS_W-1:0] ENTRY = cos_entry(g);
    assign rom_mem[g] = ENTRY;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= $signed(rom_mem[rd_addr]);
  end

endmodule

// ===== rtl/hws_mul.sv =====
// ----------------------------------------------------------------------------
// hws_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module hws_mul import hws_pkg::*; (
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] op_a,
  input  logic signed [MUL_B_W-1:0] op_b,
  output logic signed [MUL_P_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

// ===== rtl/harmonic_waveform_synth_core.sv =====
// ----------------------------------------------------------------------------
// harmonic_waveform_synth_core: additive cosine synthesiser with 12-bit DAC code.
// A request passes through RUN, where N harmonics each take one multiplier pass, then
// SCALE, DIV and FIX; no new request is accepted until the result is loaded in FIX.
// Synchronous reset restores the default registers and zeroes phase and time.
// ----------------------------------------------------------------------------
module harmonic_waveform_synth_core import hws_pkg::*; #(
  parameter int MAX_HARMONICS   = MAX_HARMONICS_DEF,
  parameter int COS_TABLE_DEPTH = COS_TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_tick,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CODE_W-1:0]     out_dac_code,
  output logic                  out_clipped
);

  localparam int CNT_W      = $clog2(MAX_HARMONICS + 1);
  localparam int IDX_W      = $clog2(COS_TABLE_DEPTH);
  localparam int IDX_PROD_W = PHASE_W + $clog2(COS_TABLE_DEPTH + 1);
  localparam int ACC_W      = 35 + CNT_W;
  localparam int R_W        = X_W + 1;

  hws_state_t state_r, state_nxt;

  logic [HC_W-1:0]    harmonic_count_r;
  logic [PHASE_W-1:0] phase_step_r;
  logic [TICK_W-1:0]  wrap_ticks_r;
  logic [DC_W-1:0]    dc_level_r;
  logic [PHASE_W-1:0] phase_accum_r, phase_accum_nxt, phase_base;
  logic [TICK_W-1:0]  tick_count_r, tick_count_nxt, tick_base;

  logic [CNT_W-1:0]   count_r, count_sat;
  logic [CNT_W-1:0]   issue_k_r, issue_k_nxt;
  logic [PHASE_W-1:0] hp_r, hp_nxt, base_phase_r;
  logic [MAG_W-1:0]   mag_s1_r;
  logic               s1_v_r, s2_v_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [X_W-1:0]     x_r, x_c;

  logic               out_valid_r;
  logic [CODE_W-1:0]  out_code_r, code_c;
  logic               out_clip_r, clip_c;

  logic               accept, issue, run_done, out_load;
  logic [31:0]        harm_word;
  logic [PHASE_W-1:0] ph;
  logic [IDX_PROD_W-1:0] idx_prod;
  logic [IDX_W-1:0]   cos_addr;
  logic signed [COS_W-1:0]   cos_rd;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  logic               acc_neg, acc_over;
  logic [Q_W-1:0]     q0, q_fix;
  logic [R_W-1:0]     rem;

  hws_cos_rom #(
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
  ) u_cos_rom (
    .clk       (clk),
    .rd_addr   (cos_addr),
    .rd_data_r (cos_rd)
  );

  hws_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (run_done) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: state_nxt = ST_DIV;
      ST_DIV:   state_nxt = ST_FIX;
      ST_FIX: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: outputs and multiplier operand selection.
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    issue    = (state_r == ST_RUN) && (issue_k_r != count_r);
    run_done = (state_r == ST_RUN) && !issue && !s1_v_r && !s2_v_r;
    out_load = (state_r == ST_FIX) && (!out_valid_r || out_ready);
    unique case (state_r)
      ST_SCALE: begin
        mul_a = $signed(MUL_A_W'(acc_r[SCALED_W-1:0]));
        mul_b = MUL_B_W'(SCALE_NUM);
      end
      ST_DIV: begin
        mul_a = $signed(MUL_A_W'(x_c));
        mul_b = MUL_B_W'(RECIP_K);
      end
      ST_FIX: begin
        mul_a = $signed(MUL_A_W'(x_r));
        mul_b = MUL_B_W'(RECIP_K);
      end
      default: begin
        mul_a = MUL_A_W'(cos_rd);
        mul_b = $signed(MUL_B_W'({mag_s1_r, 1'b0}));
      end
    endcase
  end

  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (32'(harmonic_count_r) > MAX_HARMONICS) begin
      count_sat = CNT_W'(MAX_HARMONICS);
    end else begin
      count_sat = CNT_W'(harmonic_count_r);
    end
  end

  // Harmonic phase and table address for the term being issued.
  always_comb begin
    harm_word = harm_entry(32'(issue_k_r));
    ph        = hp_r + harm_word[PHASE_W-1:0];
    idx_prod  = IDX_PROD_W'(ph) * IDX_PROD_W'(COS_TABLE_DEPTH);
    cos_addr  = idx_prod[PHASE_W +: IDX_W];
  end

  always_comb begin
    tick_base       = (tick_count_r >= wrap_ticks_r) ? '0 : tick_count_r;
    phase_base      = (tick_count_r >= wrap_ticks_r) ? '0 : phase_accum_r;
    tick_count_nxt  = tick_count_r;
    phase_accum_nxt = phase_accum_r;
    if (accept && in_tick) begin
      tick_count_nxt  = tick_base + 1'b1;
      phase_accum_nxt = phase_base + phase_step_r;
    end
  end

  always_comb begin
    hp_nxt      = hp_r;
    issue_k_nxt = issue_k_r;
    acc_nxt     = acc_r;
    if (accept) begin
      hp_nxt      = phase_accum_r;
      issue_k_nxt = '0;
      acc_nxt     = $signed(ACC_W'({dc_level_r, {DC_SHIFT{1'b0}}}));
    end else begin
      if (issue) begin
        hp_nxt      = hp_r + base_phase_r;
        issue_k_nxt = issue_k_r + 1'b1;
      end
      if (s2_v_r) begin
        acc_nxt = acc_r + ACC_W'(prod);
      end
    end
  end

  // Scaling: volts to code through a multiply and a reciprocal divide by 33.
  always_comb begin
    acc_neg  = acc_r[ACC_W-1];
    acc_over = acc_r >= ACC_W'(CLIP_LIMIT);
    x_c      = prod[SCALE_SHIFT +: X_W];
    q0       = prod[RECIP_SHIFT +: Q_W];
    rem      = R_W'(x_r) - (R_W'(q0) << 5) - R_W'(q0);
    q_fix    = q0 + Q_W'(rem >= R_W'(DIV_CONST));
    clip_c   = acc_neg || acc_over;
    if (acc_neg) begin
      code_c = '0;
    end else if (acc_over) begin
      code_c = '1;
    end else begin
      code_c = q_fix[CODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      harmonic_count_r <= HARMONIC_COUNT_RST;
      phase_step_r     <= PHASE_STEP_RST;
      wrap_ticks_r     <= WRAP_TICKS_RST;
      dc_level_r       <= DC_LEVEL_RST;
      phase_accum_r    <= '0;
      tick_count_r     <= '0;
      issue_k_r        <= '0;
      s1_v_r           <= 1'b0;
      s2_v_r           <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      phase_accum_r <= phase_accum_nxt;
      tick_count_r  <= tick_count_nxt;
      issue_k_r     <= issue_k_nxt;
      s1_v_r        <= issue;
      s2_v_r        <= s1_v_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_HARMONIC_COUNT: harmonic_count_r <= cfg_data[HC_W-1:0];
          CFG_PHASE_STEP:     phase_step_r     <= cfg_data[PHASE_W-1:0];
          CFG_WRAP_TICKS:     wrap_ticks_r     <= cfg_data[TICK_W-1:0];
          CFG_DC_LEVEL:       dc_level_r       <= cfg_data[DC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    hp_r  <= hp_nxt;
    acc_r <= acc_nxt;
    if (accept) begin
      base_phase_r <= phase_accum_r;
      count_r      <= count_sat;
    end
    if (issue) begin
      mag_s1_r <= harm_word[31:16];
    end
    if (state_r == ST_DIV) begin
      x_r <= x_c;
    end
    if (out_load) begin
      out_code_r <= code_c;
      out_clip_r <= clip_c;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_dac_code = out_code_r;
  assign out_clipped  = out_clip_r;

endmodule

// ===== rtl/hws_checker.sv =====
// ----------------------------------------------------------------------------
// hws_checker
// Port-level checks of the synthesiser, bound to the top level.
// ----------------------------------------------------------------------------
`include "harmonic_waveform_synth_core_defines.svh"

module hws_checker import hws_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  in_tick,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [CODE_W-1:0]     out_dac_code,
  input logic                  out_clipped
);

  `HWS_ASSERT_NEXT(a_busy_after_request, in_valid && in_ready, !in_ready ##1 !in_ready ##1 !in_ready, "request accepted before the previous one finished")
  `HWS_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(out_dac_code) && $stable(out_clipped), "stalled result changed or dropped")
  `HWS_ASSERT_SAME(a_clip_at_rail, out_valid && out_clipped, out_dac_code == '0 || out_dac_code == '1, "clip flag set on a code away from the rails")

endmodule

bind harmonic_waveform_synth_core hws_checker u_hws_checker (.*);
